// File: hdl/gpcg_pkg.sv
// ----------------------------------------------------------------------------
// Grid path cell generator package
// Shape, action and register codes and the control structures shared by the
// top level and the path walker.
// ----------------------------------------------------------------------------
package gpcg_pkg;

    // Action carried in the low bit of the input tuser
    typedef enum logic {
        ACT_START   = 1'b0,
        ACT_ADVANCE = 1'b1
    } action_t;

    // Path shapes
    typedef enum logic [1:0] {
        SHAPE_LINE  = 2'd0,
        SHAPE_LBEND = 2'd1,
        SHAPE_RING  = 2'd2,
        SHAPE_STAIR = 2'd3
    } shape_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_ROW_MIN = 2'd0,
        REG_ROW_MAX = 2'd1,
        REG_COL_MIN = 2'd2,
        REG_COL_MAX = 2'd3
    } reg_index_t;

    // Phase codes, interpreted per shape
    localparam logic [1:0] PH_LINE_COL_MAJOR = 2'd0;
    localparam logic [1:0] PH_LINE_ROW_MAJOR = 2'd1;
    localparam logic [1:0] PH_LB_ACROSS      = 2'd0;
    localparam logic [1:0] PH_LB_VERTICAL    = 2'd1;
    localparam logic [1:0] PH_RING_TOP       = 2'd0;
    localparam logic [1:0] PH_RING_BOTTOM    = 2'd1;
    localparam logic [1:0] PH_RING_LEFT      = 2'd2;
    localparam logic [1:0] PH_RING_RIGHT     = 2'd3;
    localparam logic [1:0] PH_IDLE           = 2'd0;

    // Reset value of the upper clip bounds
    localparam int BOUND_MAX_RESET = 1023;

    // Walker control state
    typedef struct packed {
        logic       active;
        shape_t     shape;
        logic [1:0] phase;
    } walk_ctrl_t;

    // Flags of one result beat
    typedef struct packed {
        logic offered;
        logic in_bounds;
        logic last;
    } res_flags_t;

endpackage

// File: hdl/grid_path_cell_generator.sv
// ----------------------------------------------------------------------------
// Grid path cell generator
// Walks a line, an L-bend, a rectangle outline or a staircase between two grid
// endpoints and delivers one candidate cell with its clip flag per input beat.
// ----------------------------------------------------------------------------
// Usage
//   The s_* channel takes one beat per request. s_tuser bit 0 is the action
//   (start or advance) and bits 2:1 the shape; s_tdata holds the two endpoints.
//   A start beat loads a new path, abandoning any path in progress, and at
//   once yields its first cell. Each advance beat yields the next cell. An
//   advance while no path runs yields a beat with every field zero.
//   Every input beat produces exactly one output beat on the m_* channel:
//   tdata holds the cell, tuser says whether a cell is offered and whether it
//   lies inside the clip box, and tlast marks the final cell of the path.
//   The cfg_* channel writes the four clip bounds; it is always ready and is
//   meant to be used only while no beat is in flight.
// Timing
//   A beat is captured in the input register, walked by the combinational path
//   step and placed in the output register. One beat per cycle is sustained
//   while m_tready keeps up, set by the error-term add and compare of the path
//   step, which closes the state loop.
// Reset and back-pressure
//   Reset empties both registers, clears the path state (no path runs) and sets
//   the clip box to rows and columns 0 to 1023. When m_tready is low the output
//   register holds its beat, the input register fills, and s_tready then falls.
// ----------------------------------------------------------------------------
module grid_path_cell_generator #(
    parameter int COORD_WIDTH = 11
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // Request stream
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // tdata: start_row, start_col, end_row, end_col, zero padding
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
    // tuser: action, shape[1:0]
    input  logic [2:0]                               s_tuser,
    // Cell stream
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // tdata: cell_row, cell_col, zero padding
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]       m_tdata,
    // tuser: offered, in_bounds
    output logic [1:0]                               m_tuser,
    output logic                                     m_tlast,
    // Configuration writes
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [1:0]                               cfg_index,
    input  logic [COORD_WIDTH-1:0]                   cfg_data
);

    localparam int W      = COORD_WIDTH;
    localparam int EW     = COORD_WIDTH + 3;
    localparam int CW     = COORD_WIDTH + 1;
    localparam int OUT_DW = ((2*COORD_WIDTH+7)/8)*8;
    localparam logic signed [W-1:0] MAX_RESET =
        (W >= 11) ? W'(gpcg_pkg::BOUND_MAX_RESET) : {1'b0, {(W-1){1'b1}}};

    // Clip box
    logic signed [W-1:0] row_min_reg, row_max_reg, col_min_reg, col_max_reg;

    // Handshake control
    logic in_valid_reg;
    logic out_valid_reg;
    logic s_fire;
    logic proc_fire;

    // Raw request fields
    logic signed [W-1:0] r0, c0, r1, c1;
    gpcg_pkg::shape_t    in_shape;
    logic                in_start;
    logic signed [W:0]   diff_r, diff_c;
    logic signed [W:0]   neg_r, neg_c;
    logic [W-1:0]        mag_r, mag_c;
    logic                col_major;

    // Precomputed load values (next and registered)
    gpcg_pkg::walk_ctrl_t ld_ctrl_next, ld_ctrl_reg;
    logic signed [W-1:0]  ld_cur_row_next, ld_cur_row_reg;
    logic signed [W-1:0]  ld_cur_col_next, ld_cur_col_reg;
    logic signed [W-1:0]  ld_tgt_row_next, ld_tgt_row_reg;
    logic signed [W-1:0]  ld_tgt_col_next, ld_tgt_col_reg;
    logic signed [W-1:0]  ld_anc_row_next, ld_anc_row_reg;
    logic signed [W-1:0]  ld_anc_col_next, ld_anc_col_reg;
    logic [3:0]           ld_signs_next, ld_signs_reg;
    logic [W-1:0]         ld_dr_reg, ld_dc_reg;
    logic signed [EW-1:0] ld_err_next, ld_err_reg;
    logic [CW-1:0]        ld_cnt_next, ld_cnt_reg;
    logic                 lb_empty_next, lb_empty_reg;
    logic                 start_reg;

    // Held path state
    gpcg_pkg::walk_ctrl_t st_ctrl_reg;
    logic signed [W-1:0]  st_cur_row_reg, st_cur_col_reg;
    logic signed [W-1:0]  st_tgt_row_reg, st_tgt_col_reg;
    logic signed [W-1:0]  st_anc_row_reg, st_anc_col_reg;
    logic [3:0]           st_signs_reg;
    logic [W-1:0]         st_dr_reg, st_dc_reg;
    logic signed [EW-1:0] st_err_reg;
    logic [CW-1:0]        st_cnt_reg;

    // Walker outputs
    gpcg_pkg::walk_ctrl_t nx_ctrl;
    logic signed [W-1:0]  nx_cur_row, nx_cur_col;
    logic signed [W-1:0]  w_tgt_row, w_tgt_col, w_anc_row, w_anc_col;
    logic [3:0]           w_signs;
    logic [W-1:0]         w_dr, w_dc;
    logic signed [EW-1:0] nx_err;
    logic [CW-1:0]        nx_cnt;
    logic signed [W-1:0]  res_row, res_col;
    gpcg_pkg::res_flags_t res_flags;

    // Output register
    logic signed [W-1:0]  out_row_reg, out_col_reg;
    gpcg_pkg::res_flags_t out_flags_reg;

    // ------------------------------------------------------------------------
    // Handshakes. The input register is refilled in the same cycle it drains,
    // so a beat can enter every cycle while the output side keeps up.
    // ------------------------------------------------------------------------
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire)
                in_valid_reg <= 1'b1;
            else if (proc_fire)
                in_valid_reg <= 1'b0;

            if (proc_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_min_reg <= '0;
            row_max_reg <= MAX_RESET;
            col_min_reg <= '0;
            col_max_reg <= MAX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (gpcg_pkg::reg_index_t'(cfg_index))
                gpcg_pkg::REG_ROW_MIN: row_min_reg <= cfg_data;
                gpcg_pkg::REG_ROW_MAX: row_max_reg <= cfg_data;
                gpcg_pkg::REG_COL_MIN: col_min_reg <= cfg_data;
                gpcg_pkg::REG_COL_MAX: col_max_reg <= cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Start set-up, worked out as the beat is captured: deltas, step
    // directions, initial error term and step count, and the ring corners.
    // ------------------------------------------------------------------------
    assign r0       = s_tdata[W-1:0];
    assign c0       = s_tdata[2*W-1:W];
    assign r1       = s_tdata[3*W-1:2*W];
    assign c1       = s_tdata[4*W-1:3*W];
    assign in_shape = gpcg_pkg::shape_t'(s_tuser[2:1]);
    assign in_start = (gpcg_pkg::action_t'(s_tuser[0]) == gpcg_pkg::ACT_START);

    assign diff_r    = {r1[W-1], r1} - {r0[W-1], r0};
    assign diff_c    = {c1[W-1], c1} - {c0[W-1], c0};
    assign neg_r     = -diff_r;
    assign neg_c     = -diff_c;
    assign mag_r     = diff_r[W] ? neg_r[W-1:0] : diff_r[W-1:0];
    assign mag_c     = diff_c[W] ? neg_c[W-1:0] : diff_c[W-1:0];
    assign col_major = (mag_c >= mag_r);

    always_comb
    begin
        ld_ctrl_next.active = 1'b1;
        ld_ctrl_next.shape  = in_shape;
        ld_ctrl_next.phase  = gpcg_pkg::PH_IDLE;
        ld_cur_row_next     = r0;
        ld_cur_col_next     = c0;
        ld_tgt_row_next     = r1;
        ld_tgt_col_next     = c1;
        ld_anc_row_next     = '0;
        ld_anc_col_next     = '0;
        ld_err_next         = '0;
        ld_cnt_next         = '0;
        lb_empty_next       = 1'b0;
        ld_signs_next       = {diff_c[W], (diff_c != '0), diff_r[W], (diff_r != '0)};

        case (in_shape)
            gpcg_pkg::SHAPE_LINE:
            begin
                if (col_major) begin
                    ld_ctrl_next.phase = gpcg_pkg::PH_LINE_COL_MAJOR;
                    ld_err_next = $signed({2'b00, mag_r, 1'b0}) - $signed({3'b000, mag_c});
                    ld_cnt_next = {1'b0, mag_c} + CW'(1);
                end else begin
                    ld_ctrl_next.phase = gpcg_pkg::PH_LINE_ROW_MAJOR;
                    ld_err_next = $signed({2'b00, mag_c, 1'b0}) - $signed({3'b000, mag_r});
                    ld_cnt_next = {1'b0, mag_r} + CW'(1);
                end
            end
            gpcg_pkg::SHAPE_LBEND:
            begin
                if (c0 != c1)
                    ld_ctrl_next.phase = gpcg_pkg::PH_LB_ACROSS;
                else if (r0 != r1)
                    ld_ctrl_next.phase = gpcg_pkg::PH_LB_VERTICAL;
                else
                    lb_empty_next = 1'b1;
            end
            gpcg_pkg::SHAPE_RING:
            begin
                ld_ctrl_next.phase = gpcg_pkg::PH_RING_TOP;
                ld_anc_row_next    = diff_r[W] ? r1 : r0;
                ld_tgt_row_next    = diff_r[W] ? r0 : r1;
                ld_anc_col_next    = diff_c[W] ? c1 : c0;
                ld_tgt_col_next    = diff_c[W] ? c0 : c1;
                ld_cur_row_next    = ld_anc_row_next;
                ld_cur_col_next    = ld_anc_col_next;
            end
            default:
            begin
                ld_ctrl_next.phase = gpcg_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s_fire) begin
            start_reg      <= in_start;
            ld_ctrl_reg    <= ld_ctrl_next;
            ld_cur_row_reg <= ld_cur_row_next;
            ld_cur_col_reg <= ld_cur_col_next;
            ld_tgt_row_reg <= ld_tgt_row_next;
            ld_tgt_col_reg <= ld_tgt_col_next;
            ld_anc_row_reg <= ld_anc_row_next;
            ld_anc_col_reg <= ld_anc_col_next;
            ld_signs_reg   <= ld_signs_next;
            ld_dr_reg      <= mag_r;
            ld_dc_reg      <= mag_c;
            ld_err_reg     <= ld_err_next;
            ld_cnt_reg     <= ld_cnt_next;
            lb_empty_reg   <= lb_empty_next;
        end
    end

    // ------------------------------------------------------------------------
    // Path step
    // ------------------------------------------------------------------------
    gpcg_walker #(
        .W  (W),
        .EW (EW),
        .CW (CW)
    ) u_walker (
        .start      (start_reg),
        .lb_empty   (lb_empty_reg),
        .ld_ctrl    (ld_ctrl_reg),
        .ld_cur_row (ld_cur_row_reg),
        .ld_cur_col (ld_cur_col_reg),
        .ld_tgt_row (ld_tgt_row_reg),
        .ld_tgt_col (ld_tgt_col_reg),
        .ld_anc_row (ld_anc_row_reg),
        .ld_anc_col (ld_anc_col_reg),
        .ld_signs   (ld_signs_reg),
        .ld_dr      (ld_dr_reg),
        .ld_dc      (ld_dc_reg),
        .ld_err     (ld_err_reg),
        .ld_cnt     (ld_cnt_reg),
        .st_ctrl    (st_ctrl_reg),
        .st_cur_row (st_cur_row_reg),
        .st_cur_col (st_cur_col_reg),
        .st_tgt_row (st_tgt_row_reg),
        .st_tgt_col (st_tgt_col_reg),
        .st_anc_row (st_anc_row_reg),
        .st_anc_col (st_anc_col_reg),
        .st_signs   (st_signs_reg),
        .st_dr      (st_dr_reg),
        .st_dc      (st_dc_reg),
        .st_err     (st_err_reg),
        .st_cnt     (st_cnt_reg),
        .row_min    (row_min_reg),
        .row_max    (row_max_reg),
        .col_min    (col_min_reg),
        .col_max    (col_max_reg),
        .nx_ctrl    (nx_ctrl),
        .nx_cur_row (nx_cur_row),
        .nx_cur_col (nx_cur_col),
        .w_tgt_row  (w_tgt_row),
        .w_tgt_col  (w_tgt_col),
        .w_anc_row  (w_anc_row),
        .w_anc_col  (w_anc_col),
        .w_signs    (w_signs),
        .w_dr       (w_dr),
        .w_dc       (w_dc),
        .nx_err     (nx_err),
        .nx_cnt     (nx_cnt),
        .res_row    (res_row),
        .res_col    (res_col),
        .res_flags  (res_flags)
    );

    // Path state advances only when a beat is walked into the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_ctrl_reg    <= '{active: 1'b0, shape: gpcg_pkg::SHAPE_LINE,
                                phase: gpcg_pkg::PH_IDLE};
            st_cur_row_reg <= '0;
            st_cur_col_reg <= '0;
            st_tgt_row_reg <= '0;
            st_tgt_col_reg <= '0;
            st_anc_row_reg <= '0;
            st_anc_col_reg <= '0;
            st_signs_reg   <= '0;
            st_dr_reg      <= '0;
            st_dc_reg      <= '0;
            st_err_reg     <= '0;
            st_cnt_reg     <= '0;
        end else if (proc_fire) begin
            st_ctrl_reg    <= nx_ctrl;
            st_cur_row_reg <= nx_cur_row;
            st_cur_col_reg <= nx_cur_col;
            st_tgt_row_reg <= w_tgt_row;
            st_tgt_col_reg <= w_tgt_col;
            st_anc_row_reg <= w_anc_row;
            st_anc_col_reg <= w_anc_col;
            st_signs_reg   <= w_signs;
            st_dr_reg      <= w_dr;
            st_dc_reg      <= w_dc;
            st_err_reg     <= nx_err;
            st_cnt_reg     <= nx_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire) begin
            out_row_reg   <= res_row;
            out_col_reg   <= res_col;
            out_flags_reg <= res_flags;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DW'({out_col_reg, out_row_reg});
    assign m_tuser  = {out_flags_reg.in_bounds, out_flags_reg.offered};
    assign m_tlast  = out_flags_reg.last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // A beat without a cell carries a zero cell and is never inside the box.
    a_empty_beat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0) && !m_tuser[1])
        else $error("beat without a cell carries a cell or clip flag");

    // The walk ends on the beat that is marked last.
    a_last_ends_path: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && res_flags.last) |=> !st_ctrl_reg.active)
        else $error("path still active after its last cell");

    // A walked beat always reaches the output register.
    a_walk_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire |=> out_valid_reg)
        else $error("walked beat lost before the output register");

    // An empty input register never refuses a beat.
    a_empty_input_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input refused while its register is empty");

endmodule

// File: hdl/gpcg_walker.sv
// ----------------------------------------------------------------------------
// Grid path walker
// Combinational step of the path: selects the freshly loaded or the held
// path state, produces the current cell with its clip flag and the next state.
// ----------------------------------------------------------------------------
module gpcg_walker #(
    parameter int W  = 11,
    parameter int EW = 14,
    parameter int CW = 12
) (
    input  logic                      start,
    input  logic                      lb_empty,
    // Values loaded by a start beat
    input  gpcg_pkg::walk_ctrl_t      ld_ctrl,
    input  logic signed [W-1:0]       ld_cur_row,
    input  logic signed [W-1:0]       ld_cur_col,
    input  logic signed [W-1:0]       ld_tgt_row,
    input  logic signed [W-1:0]       ld_tgt_col,
    input  logic signed [W-1:0]       ld_anc_row,
    input  logic signed [W-1:0]       ld_anc_col,
    input  logic [3:0]                ld_signs,
    input  logic [W-1:0]              ld_dr,
    input  logic [W-1:0]              ld_dc,
    input  logic signed [EW-1:0]      ld_err,
    input  logic [CW-1:0]             ld_cnt,
    // Held path state
    input  gpcg_pkg::walk_ctrl_t      st_ctrl,
    input  logic signed [W-1:0]       st_cur_row,
    input  logic signed [W-1:0]       st_cur_col,
    input  logic signed [W-1:0]       st_tgt_row,
    input  logic signed [W-1:0]       st_tgt_col,
    input  logic signed [W-1:0]       st_anc_row,
    input  logic signed [W-1:0]       st_anc_col,
    input  logic [3:0]                st_signs,
    input  logic [W-1:0]              st_dr,
    input  logic [W-1:0]              st_dc,
    input  logic signed [EW-1:0]      st_err,
    input  logic [CW-1:0]             st_cnt,
    // Clip box
    input  logic signed [W-1:0]       row_min,
    input  logic signed [W-1:0]       row_max,
    input  logic signed [W-1:0]       col_min,
    input  logic signed [W-1:0]       col_max,
    // Next state (signs, deltas, targets and anchors are taken from w_*)
    output gpcg_pkg::walk_ctrl_t      nx_ctrl,
    output logic signed [W-1:0]       nx_cur_row,
    output logic signed [W-1:0]       nx_cur_col,
    output logic signed [W-1:0]       w_tgt_row,
    output logic signed [W-1:0]       w_tgt_col,
    output logic signed [W-1:0]       w_anc_row,
    output logic signed [W-1:0]       w_anc_col,
    output logic [3:0]                w_signs,
    output logic [W-1:0]              w_dr,
    output logic [W-1:0]              w_dc,
    output logic signed [EW-1:0]      nx_err,
    output logic [CW-1:0]             nx_cnt,
    // Result
    output logic signed [W-1:0]       res_row,
    output logic signed [W-1:0]       res_col,
    output gpcg_pkg::res_flags_t      res_flags
);

    gpcg_pkg::walk_ctrl_t    w_ctrl;
    logic signed [W-1:0]     w_row;
    logic signed [W-1:0]     w_col;
    logic signed [EW-1:0]    w_err;
    logic [CW-1:0]           w_cnt;
    logic signed [W-1:0]     row_stepped;
    logic signed [W-1:0]     col_stepped;
    logic                    row_ok;
    logic                    col_ok;
    logic                    cur_col_ok;
    logic signed [EW-1:0]    two_dr;
    logic signed [EW-1:0]    two_dc;
    logic signed [W:0]       ring_height;
    logic signed [W:0]       row_plus_one;
    logic                    last;

    // One unit step of a coordinate: bit 0 of mv/dec pair moves, bit 1 decrements
    function automatic logic signed [W-1:0] step_coord(
        input logic signed [W-1:0] c,
        input logic                mv,
        input logic                dec
    );
        logic signed [W-1:0] r;
        if (!mv)
            r = c;
        else if (dec)
            r = c - W'(1);
        else
            r = c + W'(1);
        return r;
    endfunction

    assign w_ctrl    = start ? ld_ctrl    : st_ctrl;
    assign w_row     = start ? ld_cur_row : st_cur_row;
    assign w_col     = start ? ld_cur_col : st_cur_col;
    assign w_tgt_row = start ? ld_tgt_row : st_tgt_row;
    assign w_tgt_col = start ? ld_tgt_col : st_tgt_col;
    assign w_anc_row = start ? ld_anc_row : st_anc_row;
    assign w_anc_col = start ? ld_anc_col : st_anc_col;
    assign w_signs   = start ? ld_signs   : st_signs;
    assign w_dr      = start ? ld_dr      : st_dr;
    assign w_dc      = start ? ld_dc      : st_dc;
    assign w_err     = start ? ld_err     : st_err;
    assign w_cnt     = start ? ld_cnt     : st_cnt;

    assign row_stepped  = step_coord(w_row, w_signs[0], w_signs[1]);
    assign col_stepped  = step_coord(w_col, w_signs[2], w_signs[3]);
    assign row_ok       = (w_row >= row_min) && (w_row <= row_max);
    assign col_ok       = (w_col >= col_min) && (w_col <= col_max);
    assign cur_col_ok   = col_ok;
    assign two_dr       = $signed({2'b00, w_dr, 1'b0});
    assign two_dc       = $signed({2'b00, w_dc, 1'b0});
    assign ring_height  = {w_tgt_row[W-1], w_tgt_row} - {w_anc_row[W-1], w_anc_row};
    assign row_plus_one = {w_row[W-1], w_row} + (W+1)'(1);

    always_comb
    begin
        nx_ctrl    = w_ctrl;
        nx_cur_row = w_row;
        nx_cur_col = w_col;
        nx_err     = w_err;
        nx_cnt     = w_cnt;
        res_row    = w_row;
        res_col    = w_col;
        res_flags  = '{offered: 1'b1, in_bounds: row_ok && col_ok, last: 1'b0};
        last       = 1'b0;

        if (start && lb_empty) begin
            // An L-bend whose endpoints coincide has no cell at all
            res_row   = '0;
            res_col   = '0;
            res_flags = '{offered: 1'b0, in_bounds: 1'b0, last: 1'b1};
            last      = 1'b1;
        end else if (!w_ctrl.active) begin
            res_row   = '0;
            res_col   = '0;
            res_flags = '{offered: 1'b0, in_bounds: 1'b0, last: 1'b0};
        end else begin
            case (w_ctrl.shape)
                gpcg_pkg::SHAPE_LINE:
                begin
                    last = (w_cnt <= CW'(1));
                    if (!last) begin
                        nx_cnt = w_cnt - CW'(1);
                        if (w_ctrl.phase == gpcg_pkg::PH_LINE_COL_MAJOR) begin
                            nx_cur_col = col_stepped;
                            if (w_err > 0) begin
                                nx_cur_row = row_stepped;
                                nx_err     = w_err + two_dr - two_dc;
                            end else begin
                                nx_err     = w_err + two_dr;
                            end
                        end else begin
                            nx_cur_row = row_stepped;
                            if (w_err > 0) begin
                                nx_cur_col = col_stepped;
                                nx_err     = w_err + two_dc - two_dr;
                            end else begin
                                nx_err     = w_err + two_dc;
                            end
                        end
                    end
                end
                gpcg_pkg::SHAPE_LBEND:
                begin
                    if (w_ctrl.phase == gpcg_pkg::PH_LB_ACROSS) begin
                        if (w_col != w_tgt_col)
                            nx_cur_col = col_stepped;
                        else if (w_row != w_tgt_row)
                            nx_ctrl.phase = gpcg_pkg::PH_LB_VERTICAL;
                        else
                            last = 1'b1;
                    end else begin
                        if (w_row != w_tgt_row)
                            nx_cur_row = row_stepped;
                        else
                            last = 1'b1;
                    end
                end
                gpcg_pkg::SHAPE_RING:
                begin
                    case (w_ctrl.phase)
                        gpcg_pkg::PH_RING_TOP:
                        begin
                            res_row = w_anc_row;
                            res_flags.in_bounds = (w_anc_row >= row_min) && cur_col_ok;
                            nx_ctrl.phase = gpcg_pkg::PH_RING_BOTTOM;
                        end
                        gpcg_pkg::PH_RING_BOTTOM:
                        begin
                            res_row = w_tgt_row;
                            res_flags.in_bounds = (w_tgt_row <= row_max) && cur_col_ok;
                            if (w_col != w_tgt_col) begin
                                nx_cur_col    = w_col + W'(1);
                                nx_ctrl.phase = gpcg_pkg::PH_RING_TOP;
                            end else if (ring_height >= (W+1)'(2)) begin
                                nx_cur_row    = w_anc_row + W'(1);
                                nx_ctrl.phase = gpcg_pkg::PH_RING_LEFT;
                            end else begin
                                last = 1'b1;
                            end
                        end
                        gpcg_pkg::PH_RING_LEFT:
                        begin
                            res_col = w_anc_col;
                            res_flags.in_bounds = row_ok && (w_anc_col >= col_min);
                            nx_ctrl.phase = gpcg_pkg::PH_RING_RIGHT;
                        end
                        default:
                        begin
                            res_col = w_tgt_col;
                            res_flags.in_bounds = row_ok && (w_tgt_col <= col_max);
                            if (row_plus_one < $signed({w_tgt_row[W-1], w_tgt_row})) begin
                                nx_cur_row    = row_plus_one[W-1:0];
                                nx_ctrl.phase = gpcg_pkg::PH_RING_LEFT;
                            end else begin
                                last = 1'b1;
                            end
                        end
                    endcase
                end
                default:
                begin
                    last = (w_row == w_tgt_row) && (w_col == w_tgt_col);
                    if (!last) begin
                        if (w_row != w_tgt_row)
                            nx_cur_row = row_stepped;
                        if (w_col != w_tgt_col)
                            nx_cur_col = col_stepped;
                    end
                end
            endcase
            res_flags.last = last;
        end

        if (last)
            nx_ctrl.active = 1'b0;
    end

endmodule

// File: dv/grid_path_cell_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Grid path cell generator testbench
// Drives start and advance beats into the path walker and scores every cell
// beat against a behavioural path predictor held in the bench, across several
// clip boxes, with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module grid_path_cell_generator_tb;

    localparam int CW            = 11;
    localparam int SD_W          = ((4 * CW + 7) / 8) * 8;
    localparam int MD_W          = ((2 * CW + 7) / 8) * 8;
    localparam int CMIN          = -(1 << (CW - 1));
    localparam int CMAX          = (1 << (CW - 1)) - 1;
    localparam int HOLD_CYCLES   = 48;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int PHASE_BEATS   = 210;

    // One request beat as the bench sees it.
    typedef struct packed {
        gpcg_pkg::action_t     action;
        gpcg_pkg::shape_t      shape;
        logic signed [CW-1:0]  r0;
        logic signed [CW-1:0]  c0;
        logic signed [CW-1:0]  r1;
        logic signed [CW-1:0]  c1;
    } path_req_t;

    // One cell beat, unpacked from m_tdata, m_tuser and m_tlast.
    typedef struct packed {
        logic signed [CW-1:0]  row;
        logic signed [CW-1:0]  col;
        logic                  offered;
        logic                  in_bounds;
        logic                  last;
    } cell_t;

    // A row of the directed list; typed cells replace the predicted ones.
    typedef struct packed {
        path_req_t  req;
        logic       has_typed;
        cell_t      typed;
    } primer_row_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [SD_W-1:0]    s_tdata;
    logic [2:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [MD_W-1:0]    m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [CW-1:0]      cfg_data;

    grid_path_cell_generator #(
        .COORD_WIDTH (CW)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Path predictor state: the bench's own copy of the clip box and the walk.
    // ------------------------------------------------------------------------
    int                box_row_lo = 0;
    int                box_row_hi = gpcg_pkg::BOUND_MAX_RESET;
    int                box_col_lo = 0;
    int                box_col_hi = gpcg_pkg::BOUND_MAX_RESET;

    bit                path_on    = 1'b0;
    gpcg_pkg::shape_t  path_shape = gpcg_pkg::SHAPE_LINE;
    logic [1:0]        path_phase = gpcg_pkg::PH_IDLE;
    int                at_row     = 0;
    int                at_col     = 0;
    int                goal_row   = 0;
    int                goal_col   = 0;
    int                base_row   = 0;
    int                base_col   = 0;
    int                dir_row    = 0;
    int                dir_col    = 0;
    int                span_row   = 0;
    int                span_col   = 0;
    int                err_acc    = 0;
    int                cells_left = 0;

    // Cells still owed by the block, oldest first.
    cell_t       cells_due[$];
    primer_row_t primer[$];

    int          flaws         = 0;
    int          beats_sent    = 0;
    int unsigned cycles_run    = 0;
    bit          src_gaps      = 1'b1;
    bit          sink_gaps     = 1'b1;
    bit          sink_hold_req = 1'b0;

    function automatic bit row_ok(input int r);
        return r >= box_row_lo && r <= box_row_hi;
    endfunction

    function automatic int col_lo_bound();
        return box_col_lo;
    endfunction

    function automatic bit col_ok(input int c);
        return c >= col_lo_bound() && c <= box_col_hi;
    endfunction

    function automatic logic signed [CW-1:0] to_coord(input int v);
        int w;
        w = v < CMIN ? CMIN : (v > CMAX ? CMAX : v);
        return w[CW-1:0];
    endfunction

    function automatic cell_t mk_cell(input int r, input int c, input bit off,
                                      input bit inb, input bit fin);
        cell_t o;
        o.row       = to_coord(r);
        o.col       = to_coord(c);
        o.offered   = off;
        o.in_bounds = inb;
        o.last      = fin;
        return o;
    endfunction

    // Works out the cell that one accepted request beat yields and moves the
    // walk on by one step.
    function automatic cell_t walk_step(input path_req_t q);
        cell_t o;
        int    r0;
        int    c0;
        int    r1;
        int    c1;
        bit    done;
        o    = '0;
        done = 1'b0;
        if (q.action == gpcg_pkg::ACT_START)
        begin
            r0         = int'(q.r0);
            c0         = int'(q.c0);
            r1         = int'(q.r1);
            c1         = int'(q.c1);
            span_row   = r1 >= r0 ? r1 - r0 : r0 - r1;
            span_col   = c1 >= c0 ? c1 - c0 : c0 - c1;
            dir_row    = r1 > r0 ? 1 : (r1 < r0 ? -1 : 0);
            dir_col    = c1 > c0 ? 1 : (c1 < c0 ? -1 : 0);
            path_shape = q.shape;
            at_row     = r0;
            at_col     = c0;
            goal_row   = r1;
            goal_col   = c1;
            base_row   = 0;
            base_col   = 0;
            path_on    = 1'b1;
            path_phase = gpcg_pkg::PH_IDLE;
            err_acc    = 0;
            cells_left = 0;
            case (path_shape)
                gpcg_pkg::SHAPE_LINE:
                begin
                    if (span_col >= span_row)
                    begin
                        path_phase = gpcg_pkg::PH_LINE_COL_MAJOR;
                        err_acc    = 2 * span_row - span_col;
                        cells_left = span_col + 1;
                    end
                    else
                    begin
                        path_phase = gpcg_pkg::PH_LINE_ROW_MAJOR;
                        err_acc    = 2 * span_col - span_row;
                        cells_left = span_row + 1;
                    end
                end
                gpcg_pkg::SHAPE_LBEND:
                begin
                    if (c0 != c1)
                        path_phase = gpcg_pkg::PH_LB_ACROSS;
                    else if (r0 != r1)
                        path_phase = gpcg_pkg::PH_LB_VERTICAL;
                    else
                    begin
                        // Both endpoints coincide: no cell, but the path ends.
                        path_on = 1'b0;
                        o.last  = 1'b1;
                        return o;
                    end
                end
                gpcg_pkg::SHAPE_RING:
                begin
                    base_row = r0 < r1 ? r0 : r1;
                    goal_row = r0 > r1 ? r0 : r1;
                    base_col = c0 < c1 ? c0 : c1;
                    goal_col = c0 > c1 ? c0 : c1;
                    at_row   = base_row;
                    at_col   = base_col;
                end
                default:
                begin
                end
            endcase
        end
        if (!path_on)
            return o;
        o.offered = 1'b1;
        case (path_shape)
            gpcg_pkg::SHAPE_LINE:
            begin
                o.row       = to_coord(at_row);
                o.col       = to_coord(at_col);
                o.in_bounds = row_ok(at_row) && col_ok(at_col);
                done        = cells_left <= 1;
                if (!done)
                begin
                    if (path_phase == gpcg_pkg::PH_LINE_COL_MAJOR)
                    begin
                        if (err_acc > 0)
                        begin
                            at_row  += dir_row;
                            err_acc -= 2 * span_col;
                        end
                        err_acc += 2 * span_row;
                        at_col  += dir_col;
                    end
                    else
                    begin
                        if (err_acc > 0)
                        begin
                            at_col  += dir_col;
                            err_acc -= 2 * span_row;
                        end
                        err_acc += 2 * span_col;
                        at_row  += dir_row;
                    end
                    cells_left--;
                end
            end
            gpcg_pkg::SHAPE_LBEND:
            begin
                o.row       = to_coord(at_row);
                o.col       = to_coord(at_col);
                o.in_bounds = row_ok(at_row) && col_ok(at_col);
                if (path_phase == gpcg_pkg::PH_LB_ACROSS)
                begin
                    if (at_col != goal_col)
                        at_col += dir_col;
                    else if (at_row != goal_row)
                        path_phase = gpcg_pkg::PH_LB_VERTICAL;
                    else
                        done = 1'b1;
                end
                else if (at_row != goal_row)
                    at_row += dir_row;
                else
                    done = 1'b1;
            end
            gpcg_pkg::SHAPE_RING:
            begin
                // Each edge of the outline tests only the bound that faces it, plus both bounds along its length.
                case (path_phase)
                    gpcg_pkg::PH_RING_TOP:
                    begin
                        o.row       = to_coord(base_row);
                        o.col       = to_coord(at_col);
                        o.in_bounds = base_row >= box_row_lo && col_ok(at_col);
                        path_phase  = gpcg_pkg::PH_RING_BOTTOM;
                    end
                    gpcg_pkg::PH_RING_BOTTOM:
                    begin
                        o.row       = to_coord(goal_row);
                        o.col       = to_coord(at_col);
                        o.in_bounds = goal_row <= box_row_hi && col_ok(at_col);
                        if (at_col != goal_col)
                        begin
                            at_col++;
                            path_phase = gpcg_pkg::PH_RING_TOP;
                        end
                        else if (goal_row - base_row >= 2)
                        begin
                            at_row     = base_row + 1;
                            path_phase = gpcg_pkg::PH_RING_LEFT;
                        end
                        else
                            done = 1'b1;
                    end
                    gpcg_pkg::PH_RING_LEFT:
                    begin
                        o.row       = to_coord(at_row);
                        o.col       = to_coord(base_col);
                        o.in_bounds = row_ok(at_row) && base_col >= box_col_lo;
                        path_phase  = gpcg_pkg::PH_RING_RIGHT;
                    end
                    default:
                    begin
                        o.row       = to_coord(at_row);
                        o.col       = to_coord(goal_col);
                        o.in_bounds = row_ok(at_row) && goal_col <= box_col_hi;
                        if (at_row + 1 < goal_row)
                        begin
                            at_row++;
                            path_phase = gpcg_pkg::PH_RING_LEFT;
                        end
                        else
                            done = 1'b1;
                    end
                endcase
            end
            default:
            begin
                o.row       = to_coord(at_row);
                o.col       = to_coord(at_col);
                o.in_bounds = row_ok(at_row) && col_ok(at_col);
                done        = at_row == goal_row && at_col == goal_col;
                if (!done)
                begin
                    if (at_row != goal_row)
                        at_row += dir_row;
                    if (at_col != goal_col)
                        at_col += dir_col;
                end
            end
        endcase
        o.last = done;
        if (done)
            path_on = 1'b0;
        return o;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, (1 << CW) - 1)) + CMIN;
    endfunction

    // Half the time anywhere on the grid, otherwise around the clip box.
    function automatic int near_coord(input int lo, input int hi);
        int a;
        int b;
        a = lo < hi ? lo : hi;
        b = lo < hi ? hi : lo;
        if ($urandom_range(0, 1) == 0)
            return any_coord();
        return a - 8 + int'($urandom_range(0, b - a + 16));
    endfunction

    // An advance beat whose unused fields carry rubbish.
    function automatic path_req_t noisy_advance();
        path_req_t q;
        q.action = gpcg_pkg::ACT_ADVANCE;
        q.shape  = gpcg_pkg::shape_t'($urandom_range(0, 3));
        q.r0     = to_coord(any_coord());
        q.c0     = to_coord(any_coord());
        q.r1     = to_coord(any_coord());
        q.c1     = to_coord(any_coord());
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("** grid_path_cell_generator: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offers one beat after a random gap, waits for the handshake and records
    // the cell the block now owes.
    task automatic offer_request(input path_req_t q, input bit has_typed,
                                 input cell_t typed);
        int    gap;
        cell_t pred;
        gap = src_gaps ? $urandom_range(0, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid              = 1'b1;
        s_tdata               = '0;
        s_tdata[CW-1:0]       = q.r0;
        s_tdata[2*CW-1:CW]    = q.c0;
        s_tdata[3*CW-1:2*CW]  = q.r1;
        s_tdata[4*CW-1:3*CW]  = q.c1;
        s_tuser               = {q.shape, q.action};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = walk_step(q);
        cells_due.push_back(has_typed ? typed : pred);
        beats_sent++;
    endtask

    // Drops the request stream and waits until every owed cell is in.
    task automatic quiesce();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bound(input gpcg_pkg::reg_index_t idx, input int v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = to_coord(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            gpcg_pkg::REG_ROW_MIN: box_row_lo = v;
            gpcg_pkg::REG_ROW_MAX: box_row_hi = v;
            gpcg_pkg::REG_COL_MIN: box_col_lo = v;
            default:               box_col_hi = v;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_box(input int rlo, input int rhi, input int clo, input int chi);
        write_bound(gpcg_pkg::REG_ROW_MIN, rlo);
        write_bound(gpcg_pkg::REG_ROW_MAX, rhi);
        write_bound(gpcg_pkg::REG_COL_MIN, clo);
        write_bound(gpcg_pkg::REG_COL_MAX, chi);
    endtask

    task automatic add_primer(input gpcg_pkg::action_t a, input gpcg_pkg::shape_t s,
                              input int r0, input int c0, input int r1, input int c1,
                              input bit has, input cell_t e);
        primer_row_t p;
        p.req.action = a;
        p.req.shape  = s;
        p.req.r0     = to_coord(r0);
        p.req.c0     = to_coord(c0);
        p.req.r1     = to_coord(r1);
        p.req.c1     = to_coord(c1);
        p.has_typed  = has;
        p.typed      = e;
        primer.push_back(p);
    endtask

    // Mostly whole, short paths near the clip box; a few run across the full
    // grid and are cut short, some are abandoned early, and some are followed
    // by advances with no path running.
    task automatic run_paths(input int budget);
        path_req_t q;
        int        stop_at;
        int        cap;
        int        n;
        int        extra;
        int        r0;
        int        c0;
        int        sel;
        stop_at = beats_sent + budget;
        while (beats_sent < stop_at)
        begin
            q.action = gpcg_pkg::ACT_START;
            q.shape  = gpcg_pkg::shape_t'($urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0)
            begin
                q.r0 = to_coord(any_coord());
                q.c0 = to_coord(any_coord());
                q.r1 = to_coord(any_coord());
                q.c1 = to_coord(any_coord());
                cap  = $urandom_range(1, 24);
            end
            else
            begin
                r0   = near_coord(box_row_lo, box_row_hi);
                c0   = near_coord(box_col_lo, box_col_hi);
                q.r0 = to_coord(r0);
                q.c0 = to_coord(c0);
                q.r1 = to_coord(r0 + int'($urandom_range(0, 24)) - 12);
                q.c1 = to_coord(c0 + int'($urandom_range(0, 24)) - 12);
                sel  = $urandom_range(0, 15);
                // Points and axis-aligned paths make the empty legs and the
                // one-row or one-column rings.
                if (sel == 0 || sel == 2)
                    q.r1 = q.r0;
                if (sel == 1 || sel == 2)
                    q.c1 = q.c0;
                cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 1000;
            end
            offer_request(q, 1'b0, '0);
            n = 0;
            while (path_on && n < cap)
            begin
                offer_request(noisy_advance(), 1'b0, '0);
                n++;
            end
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (extra) offer_request(noisy_advance(), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Cell side: draws a stall per beat, honours one long hold, and scores
    // each beat against the oldest owed cell.
    // ------------------------------------------------------------------------
    initial
    begin : cell_sink
        cell_t got;
        cell_t want;
        int    stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = sink_gaps ? $urandom_range(0, 3) : 0;
            if (sink_hold_req)
            begin
                // Long enough for both registers to fill and s_tready to fall.
                stall         = HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            got.row       = m_tdata[CW-1:0];
            got.col       = m_tdata[2*CW-1:CW];
            got.offered   = m_tuser[0];
            got.in_bounds = m_tuser[1];
            got.last      = m_tlast;
            if (cells_due.size() == 0)
            begin
                flaws++;
                if (flaws <= 10)
                    $display("unexpected cell beat: row %0d col %0d offered %0b",
                             got.row, got.col, got.offered);
            end
            else
            begin
                want = cells_due.pop_front();
                if (got.row !== want.row || got.col !== want.col
                    || got.offered !== want.offered || got.in_bounds !== want.in_bounds
                    || got.last !== want.last)
                begin
                    flaws++;
                    if (flaws <= 10)
                    begin
                        $write("cell mismatch: expected row %0d col %0d off %0b inb %0b ",
                               want.row, want.col, want.offered, want.in_bounds);
                        $display("last %0b, got row %0d col %0d off %0b inb %0b last %0b",
                                 want.last, got.row, got.col, got.offered,
                                 got.in_bounds, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats under the reset clip box of rows and columns 0 to
        // 1023. An advance with no path running must come back all zero.
        add_primer(gpcg_pkg::ACT_ADVANCE, gpcg_pkg::SHAPE_LINE, 0, 0, 0, 0, 1'b1,
                   mk_cell(0, 0, 0, 0, 0));
        // An L-bend whose endpoints coincide offers nothing but ends the path.
        add_primer(gpcg_pkg::ACT_START, gpcg_pkg::SHAPE_LBEND, 5, 5, 5, 5, 1'b1,
                   mk_cell(0, 0, 0, 0, 1));
        // A one-cell line is its own last cell.
        add_primer(gpcg_pkg::ACT_START, gpcg_pkg::SHAPE_LINE, 0, 0, 0, 0, 1'b1,
                   mk_cell(0, 0, 1, 1, 1));
        // Staircase from the most negative corner, outside the box.
        add_primer(gpcg_pkg::ACT_START, gpcg_pkg::SHAPE_STAIR, CMIN, CMIN, CMAX, CMAX, 1'b1,
                   mk_cell(CMIN, CMIN, 1, 0, 0));
        add_primer(gpcg_pkg::ACT_ADVANCE, gpcg_pkg::SHAPE_LINE, 0, 0, 0, 0, 1'b0, '0);
        // A start in the middle of a path abandons it.
        add_primer(gpcg_pkg::ACT_START, gpcg_pkg::SHAPE_LINE, CMAX, CMAX, CMIN, CMIN, 1'b1,
                   mk_cell(CMAX, CMAX, 1, 1, 0));
        repeat (2)
            add_primer(gpcg_pkg::ACT_ADVANCE, gpcg_pkg::SHAPE_LINE, 0, 0, 0, 0, 1'b0, '0);
        // A steep line walks row-major.
        add_primer(gpcg_pkg::ACT_START, gpcg_pkg::SHAPE_LINE, 0, 0, 5, 2, 1'b1,
                   mk_cell(0, 0, 1, 1, 0));
        repeat (5)
            add_primer(gpcg_pkg::ACT_ADVANCE, gpcg_pkg::SHAPE_LINE, 0, 0, 0, 0, 1'b0, '0);
        // A ring given by its lower-left and upper-right corners starts at the
        // low corner.
        add_primer(gpcg_pkg::ACT_START, gpcg_pkg::SHAPE_RING, 2, 1, 0, 2, 1'b1,
                   mk_cell(0, 1, 1, 1, 0));
        repeat (5)
            add_primer(gpcg_pkg::ACT_ADVANCE, gpcg_pkg::SHAPE_LINE, 0, 0, 0, 0, 1'b0, '0);
        // An L-bend walking left then up, with the corner cell offered twice.
        add_primer(gpcg_pkg::ACT_START, gpcg_pkg::SHAPE_LBEND, 1, 3, 0, 1, 1'b1,
                   mk_cell(1, 3, 1, 1, 0));
        repeat (4)
            add_primer(gpcg_pkg::ACT_ADVANCE, gpcg_pkg::SHAPE_LINE, 0, 0, 0, 0, 1'b0, '0);
        add_primer(gpcg_pkg::ACT_ADVANCE, gpcg_pkg::SHAPE_LINE, 0, 0, 0, 0, 1'b1,
                   mk_cell(0, 0, 0, 0, 0));
        foreach (primer[i])
            offer_request(primer[i].req, primer[i].has_typed, primer[i].typed);
        quiesce();

        // Widest possible box.
        load_box(CMIN, CMAX, CMIN, CMAX);
        run_paths(PHASE_BEATS);
        quiesce();

        // A narrow box around the origin, with the cell side held off for a
        // long stretch at the start so that the block backs up.
        load_box(-6, 9, -4, 7);
        sink_hold_req = 1'b1;
        run_paths(PHASE_BEATS);
        quiesce();

        // Inverted box: every clip test fails. No gaps on either side here.
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        load_box(12, -12, CMAX, CMIN);
        run_paths(PHASE_BEATS);
        quiesce();

        // A single cell at the far corner.
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        load_box(CMAX, CMAX, CMAX, CMAX);
        run_paths(PHASE_BEATS);
        quiesce();

        // A random box, possibly inverted.
        load_box(any_coord(), any_coord(), any_coord(), any_coord());
        run_paths(PHASE_BEATS);
        quiesce();

        if (flaws == 0)
            $display("** grid_path_cell_generator: PASSED **");
        else
            $display("** grid_path_cell_generator: FAILED **");
        $finish;
    end

endmodule
